// ===== rtl/core/idalloc_pkg.sv =====
package idalloc_pkg;

  localparam int ID_BITS     = 10;
  localparam int WORD_SEL    = 5;
  localparam int WORD_W      = 1 << WORD_SEL;
  localparam int ROW_BITS    = ID_BITS - WORD_SEL;
  localparam int ROW_COUNT   = 1 << ROW_BITS;
  localparam int KCNT_W      = ROW_BITS + 1;
  localparam int ACT_W       = 3;
  localparam int IN_TDATA_W  = 16;
  localparam int OUT_TDATA_W = 16;

  localparam logic [ID_BITS-1:0] ID_INVALID = {ID_BITS{1'b1}};

  typedef enum logic [ACT_W-1:0] {
    ACT_NEXT      = 3'd0,
    ACT_NEXT_MARK = 3'd1,
    ACT_QUERY     = 3'd2,
    ACT_MARK      = 3'd3,
    ACT_UNMARK    = 3'd4,
    ACT_CLEAR     = 3'd5,
    ACT_READ      = 3'd6
  } action_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EVAL,
    ST_SCAN,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic accept;
    logic clear;
    logic set_wu;
    logic wr;
    logic wr_scan;
    logic take;
    logic set_full;
    logic step;
    logic load_out;
  } ctrl_cmd_t;

  typedef struct packed {
    logic [ACT_W-1:0] in_act;
    logic [ACT_W-1:0] act;
    logic             found;
    logic             last;
    logic             out_free;
  } dp_status_t;

endpackage

// ===== rtl/core/idalloc_ctrl.sv =====
module idalloc_ctrl (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    s_tvalid,
  output logic                    s_tready,
  input  idalloc_pkg::dp_status_t status,
  output idalloc_pkg::ctrl_cmd_t  cmd
);
  import idalloc_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    s_tready   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.accept = 1'b1;
          if (status.in_act == ACT_NEXT || status.in_act == ACT_NEXT_MARK) begin
            state_next = ST_SCAN;
          end else if (status.in_act == ACT_QUERY || status.in_act == ACT_MARK ||
                       status.in_act == ACT_UNMARK) begin
            state_next = ST_EVAL;
          end else begin
            cmd.clear  = (status.in_act == ACT_CLEAR);
            state_next = ST_DONE;
          end
        end
      end
      ST_EVAL: begin
        // word of the item's id is now in the read register
        if (status.act == ACT_QUERY) begin
          cmd.set_wu = 1'b1;
        end else begin
          cmd.wr = 1'b1;
        end
        state_next = ST_DONE;
      end
      ST_SCAN: begin
        if (status.found) begin
          cmd.take    = 1'b1;
          cmd.wr      = (status.act == ACT_NEXT_MARK);
          cmd.wr_scan = 1'b1;
          state_next  = ST_DONE;
        end else if (status.last) begin
          cmd.set_full = 1'b1;
          state_next   = ST_DONE;
        end else begin
          cmd.step = 1'b1;
        end
      end
      ST_DONE: begin
        if (status.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/core/idalloc_dp.sv =====
module idalloc_dp (
  input  logic                                clk,
  input  logic                                rst,
  input  logic [idalloc_pkg::IN_TDATA_W-1:0]  s_tdata,
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [idalloc_pkg::OUT_TDATA_W-1:0] m_tdata,
  input  idalloc_pkg::ctrl_cmd_t              cmd,
  output idalloc_pkg::dp_status_t             status
);
  import idalloc_pkg::*;

  localparam logic [KCNT_W-1:0] K_LAST = KCNT_W'(ROW_COUNT);
  localparam logic [ROW_BITS-1:0] LAST_ROW = ID_INVALID[ID_BITS-1:WORD_SEL];
  localparam logic [WORD_W-1:0] LAST_ROW_INIT = WORD_W'(1) << ID_INVALID[WORD_SEL-1:0];

  // used map: one word per row, row valid bits stand for the reset contents
  logic [WORD_W-1:0]    mem [ROW_COUNT];
  logic [ROW_COUNT-1:0] row_vld;

  logic [ACT_W-1:0]    act_q;
  logic [ID_BITS-1:0]  id_q;
  logic [ID_BITS-1:0]  cur;
  logic [ROW_BITS-1:0] w0;
  logic [WORD_SEL-1:0] b0;
  logic [KCNT_W-1:0]   kchk;
  logic                wu_r;
  logic                full_r;

  logic [ROW_BITS-1:0] rd_row_q;
  logic [WORD_W-1:0]   rd_data_q;
  logic                rd_vld_q;

  logic [ACT_W-1:0]    in_act;
  logic [ID_BITS-1:0]  in_id;
  logic [ID_BITS-1:0]  cur_inc;
  logic [ROW_BITS-1:0] rd_addr;
  logic [WORD_W-1:0]   eff;
  logic [WORD_W-1:0]   lo_mask;
  logic [WORD_W-1:0]   mask;
  logic [WORD_W-1:0]   free;
  logic [WORD_SEL-1:0] pos;
  logic                found;
  logic [WORD_SEL-1:0] wbit;
  logic [WORD_W-1:0]   wdata;

  assign in_act  = s_tdata[ACT_W-1:0];
  assign in_id   = s_tdata[ACT_W +: ID_BITS];
  assign cur_inc = cur + ID_BITS'(1);

  always_comb begin
    if (cmd.accept) begin
      if (in_act == ACT_NEXT || in_act == ACT_NEXT_MARK) begin
        rd_addr = cur_inc[ID_BITS-1:WORD_SEL];
      end else begin
        rd_addr = in_id[ID_BITS-1:WORD_SEL];
      end
    end else begin
      rd_addr = w0 + kchk[ROW_BITS-1:0] + ROW_BITS'(1);
    end
  end

  always_ff @(posedge clk) begin
    rd_row_q  <= rd_addr;
    rd_data_q <= mem[rd_addr];
    rd_vld_q  <= row_vld[rd_addr];
    if (cmd.wr) begin
      mem[rd_row_q] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      row_vld <= '0;
    end else if (cmd.wr) begin
      row_vld[rd_row_q] <= 1'b1;
    end
  end

  always_comb begin
    if (rd_vld_q) begin
      eff = rd_data_q;
    end else if (rd_row_q == LAST_ROW) begin
      eff = LAST_ROW_INIT;
    end else begin
      eff = '0;
    end
  end

  // first and last visits to the start row split it at the start bit
  always_comb begin
    lo_mask = {WORD_W{1'b1}} << b0;
    if (kchk == '0) begin
      mask = lo_mask;
    end else if (kchk == K_LAST) begin
      mask = ~lo_mask;
    end else begin
      mask = '1;
    end
    free = ~eff & mask;
  end

  always_comb begin
    pos = '0;
    for (int i = WORD_W - 1; i >= 0; i--) begin
      if (free[i]) begin
        pos = WORD_SEL'(i);
      end
    end
    found = |free;
  end

  always_comb begin
    wbit  = cmd.wr_scan ? pos : id_q[WORD_SEL-1:0];
    wdata = eff;
    wdata[wbit] = (act_q != ACT_UNMARK);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur <= ID_INVALID;
    end else if (cmd.take) begin
      cur <= {rd_row_q, pos};
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      act_q  <= in_act;
      id_q   <= in_id;
      w0     <= cur_inc[ID_BITS-1:WORD_SEL];
      b0     <= cur_inc[WORD_SEL-1:0];
      kchk   <= '0;
      wu_r   <= 1'b0;
      full_r <= 1'b0;
    end else begin
      if (cmd.step) begin
        kchk <= kchk + KCNT_W'(1);
      end
      if (cmd.set_wu) begin
        wu_r <= eff[id_q[WORD_SEL-1:0]];
      end
      if (cmd.set_full) begin
        full_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.load_out) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      m_tdata <= OUT_TDATA_W'({full_r, wu_r, cur});
    end
  end

  assign status.in_act   = in_act;
  assign status.act      = act_q;
  assign status.found    = found;
  assign status.last     = (kchk == K_LAST);
  assign status.out_free = !m_tvalid || m_tready;

endmodule

// ===== rtl/core/identity_allocator_top.sv =====
// Identity allocator over a 1024-id space, kept as a used bitmap of 32 words
// of 32 bits plus a current-id register. One transaction in gives one
// transaction out. Read current and clear go straight to the result; query,
// mark and unmark first read the word of the given id, and an advance scans
// 1 to 33 bitmap words, starting at the word that holds the id after the
// current id, one word per cycle through the single read port of the map.
// Items are handled one at a time; the next is accepted as soon as the
// previous result sits in the output register. Clear resets the per-word valid
// bits directly, so no clearing pass is needed after reset or clear.
module identity_allocator_top (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [idalloc_pkg::IN_TDATA_W-1:0]  s_tdata,  // action[2:0], id[12:3], zero pad
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [idalloc_pkg::OUT_TDATA_W-1:0] m_tdata   // id_out[9:0], was_used[10],
                                                        // full_res[11], zero pad
);
  import idalloc_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t status;

  idalloc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  idalloc_dp u_dp (
    .clk      (clk),
    .rst      (rst),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cmd      (cmd),
    .status   (status)
  );

endmodule

// ===== sim/identity_allocator_top_test.sv =====
module identity_allocator_top_test;
  import idalloc_pkg::*;

  localparam logic [ACT_W-1:0] ACT_RSVD = 3'd7;  // unused code, behaves as read
  localparam int ID_SPACE = 1 << ID_BITS;

  typedef struct packed {
    logic [ACT_W-1:0]   act;
    logic [ID_BITS-1:0] id;
  } id_request_t;

  typedef struct packed {
    logic               full_res;
    logic               was_used;
    logic [ID_BITS-1:0] id_out;
  } id_result_t;

  logic                   clk;
  logic                   rst = 1'b1;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [IN_TDATA_W-1:0]  s_tdata = '0;
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_tdata;

  id_request_t req_q[$];
  id_result_t  result_q[$];
  int          src_idle_pct = 0;
  int          snk_stall_pct = 0;
  int          mismatches = 0;
  logic        src_took = 1'b0;

  // shadow allocator state
  logic [ID_SPACE-1:0] used_bits;
  logic [ID_BITS-1:0]  cur_id;

  identity_allocator_top uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic id_result_t allocate_step(logic [ACT_W-1:0] act, logic [ID_BITS-1:0] id);
    id_result_t         r;
    logic [ID_BITS-1:0] cand;
    logic               hit;
    r = '0;
    hit = 1'b0;
    cand = cur_id;
    case (act)
      ACT_NEXT, ACT_NEXT_MARK: begin
        // last candidate is the current id itself
        for (int k = 1; k <= ID_SPACE && !hit; k++) begin
          cand = cur_id + k[ID_BITS-1:0];
          if (!used_bits[cand]) hit = 1'b1;
        end
        if (hit) begin
          cur_id = cand;
          if (act == ACT_NEXT_MARK) used_bits[cand] = 1'b1;
        end else begin
          r.full_res = 1'b1;
        end
      end
      ACT_QUERY: r.was_used = used_bits[id];
      ACT_MARK: used_bits[id] = 1'b1;
      ACT_UNMARK: used_bits[id] = 1'b0;
      ACT_CLEAR: begin
        used_bits = '0;
        used_bits[ID_INVALID] = 1'b1;
      end
      default: ;
    endcase
    r.id_out = cur_id;
    return r;
  endfunction

  // driver: a new transaction is offered once the previous one was taken
  always @(negedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || src_took) begin
      if (req_q.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
        id_request_t r;
        r = req_q.pop_front();
        s_tvalid <= 1'b1;
        s_tdata  <= {{(IN_TDATA_W - ACT_W - ID_BITS){1'b0}}, r.id, r.act};
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    m_tready <= !rst && ($urandom_range(99) >= snk_stall_pct);
  end

  // monitor: results checked first, then the accepted request is predicted
  always @(posedge clk) begin
    id_result_t want;
    if (rst) begin
      src_took <= 1'b0;
      cur_id = ID_INVALID;
      used_bits = '0;
      used_bits[ID_INVALID] = 1'b1;
    end else begin
      if (m_tvalid && m_tready) begin
        if (result_q.size() == 0) begin
          $display("%0t: unexpected result, expected none, got tdata %h", $time, m_tdata);
          mismatches++;
        end else begin
          want = result_q.pop_front();
          if (m_tdata[ID_BITS-1:0] !== want.id_out) begin
            $display("%0t: id_out expected %0d, got %0d", $time, want.id_out,
                     m_tdata[ID_BITS-1:0]);
            mismatches++;
          end
          if (m_tdata[ID_BITS] !== want.was_used) begin
            $display("%0t: was_used expected %0b, got %0b", $time, want.was_used,
                     m_tdata[ID_BITS]);
            mismatches++;
          end
          if (m_tdata[ID_BITS+1] !== want.full_res) begin
            $display("%0t: full_res expected %0b, got %0b", $time, want.full_res,
                     m_tdata[ID_BITS+1]);
            mismatches++;
          end
        end
      end
      src_took <= s_tvalid && s_tready;
      if (s_tvalid && s_tready)
        result_q.push_back(allocate_step(s_tdata[ACT_W-1:0], s_tdata[ACT_W+ID_BITS-1:ACT_W]));
    end
  end

  task automatic push_req(logic [ACT_W-1:0] act, logic [ID_BITS-1:0] id);
    id_request_t r;
    r.act = act;
    r.id  = id;
    req_q.push_back(r);
  endtask

  // biased toward the ends of the id range
  function automatic logic [ID_BITS-1:0] pick_id();
    int r;
    r = $urandom_range(99);
    if (r < 10) return '0;
    if (r < 20) return ID_INVALID;
    return ID_BITS'($urandom_range(ID_SPACE - 1));
  endfunction

  task automatic wait_drained();
    while (req_q.size() != 0 || s_tvalid || result_q.size() != 0) @(posedge clk);
  endtask

  task automatic push_mix(int n);
    logic [ACT_W-1:0] act;
    for (int i = 0; i < n; i++) begin
      act = ACT_W'($urandom_range(7));
      // keep clears rare so marks pile up
      if (act == ACT_CLEAR && $urandom_range(9) != 0) act = ACT_NEXT_MARK;
      push_req(act, pick_id());
    end
  endtask

  initial begin
    int r;

    // directed, from reset: only the invalid id is marked, current is invalid
    push_req(ACT_READ, 10'd0);
    push_req(ACT_QUERY, ID_INVALID);
    push_req(ACT_QUERY, 10'd0);
    push_req(ACT_NEXT, 10'd0);         // wraps to 0
    push_req(ACT_NEXT_MARK, 10'd0);
    push_req(ACT_MARK, 10'd2);
    push_req(ACT_MARK, ID_INVALID);
    push_req(ACT_NEXT_MARK, ID_INVALID); // skips the marked 2
    push_req(ACT_QUERY, 10'd2);
    push_req(ACT_UNMARK, 10'd2);
    push_req(ACT_QUERY, 10'd2);
    push_req(ACT_RSVD, ID_INVALID);
    push_req(ACT_RSVD, 10'd0);
    push_req(ACT_MARK, 10'd0);
    push_req(ACT_NEXT, 10'd0);
    push_req(ACT_UNMARK, ID_INVALID);
    push_req(ACT_QUERY, ID_INVALID);
    push_req(ACT_CLEAR, 10'd0);        // current id stays
    push_req(ACT_QUERY, ID_INVALID);
    push_req(ACT_QUERY, 10'd0);
    push_req(ACT_UNMARK, 10'd0);
    push_req(ACT_NEXT_MARK, 10'd0);
    push_req(ACT_READ, 10'h155);
    push_req(ACT_QUERY, 10'h2aa);

    repeat (6) @(posedge clk);
    rst <= 1'b0;
    wait_drained();

    src_idle_pct = 48;
    push_mix(12);
    wait_drained();

    src_idle_pct = 0;
    snk_stall_pct = 48;
    push_mix(12);
    wait_drained();

    // fill the whole map until advances report full, a third under each idling mode
    snk_stall_pct = 0;
    push_req(ACT_CLEAR, pick_id());
    for (int ph = 0; ph < 3; ph++) begin
      src_idle_pct  = (ph == 1) ? 48 : 0;
      snk_stall_pct = (ph == 2) ? 48 : 0;
      for (int i = 0; i < (ID_SPACE + 2) / 3; i++) begin
        push_req(ACT_NEXT_MARK, pick_id());
        if (i % 128 == 127) push_req(ACT_QUERY, pick_id());
      end
      wait_drained();
    end

    // full map: free the current id alone, then the invalid id alone
    src_idle_pct = 28;
    snk_stall_pct = 28;
    push_req(ACT_UNMARK, cur_id);
    push_req(ACT_NEXT, 10'd0);
    push_req(ACT_NEXT_MARK, 10'd0);
    push_req(ACT_NEXT, 10'd0);
    push_req(ACT_UNMARK, ID_INVALID);
    push_req(ACT_NEXT_MARK, 10'd0);
    push_req(ACT_NEXT, 10'd0);
    for (int i = 0; i < 20; i++) begin
      r = $urandom_range(99);
      if (r < 30) push_req(ACT_UNMARK, pick_id());
      else if (r < 45) push_req(ACT_NEXT, pick_id());
      else if (r < 70) push_req(ACT_NEXT_MARK, pick_id());
      else if (r < 85) push_req(ACT_QUERY, pick_id());
      else if (r < 95) push_req(ACT_MARK, pick_id());
      else push_req($urandom_range(1) ? ACT_READ : ACT_RSVD, pick_id());
    end
    wait_drained();

    repeat (50) @(posedge clk);
    if (mismatches == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

  initial begin
    #5000000;
    $display("== FAIL ==");
    $finish;
  end

endmodule
